// File: sv/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg: shared types and tables for the 4-bit character LCD interface
// Request kinds, the pin phase record and the power-up init phase table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned NibW    = 4;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RowW    = 2;
  localparam int unsigned ColW    = 5;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 24;

  // Phase index of the last phase of each sequence
  localparam logic [IdxW-1:0] InitLastIdx = IdxW'(28);
  localparam logic [IdxW-1:0] NibLastIdx  = IdxW'(1);
  localparam logic [IdxW-1:0] ByteLastIdx = IdxW'(3);
  // First init phase that belongs to the byte commands
  localparam logic [IdxW-1:0] InitByteIdx = IdxW'(9);
  // First init phase of the mode-switch nibble
  localparam logic [IdxW-1:0] InitModeIdx = IdxW'(7);

  localparam logic [HoldW-1:0] WaitHold    = HoldW'(50);
  localparam logic [HoldW-1:0] StrobeHold  = HoldW'(1);
  localparam logic [HoldW-1:0] CharHold    = HoldW'(46);
  localparam logic [HoldW-1:0] WakeHold    = HoldW'(4100);
  localparam logic [HoldW-1:0] NibCmdHold  = HoldW'(100);
  localparam logic [HoldW-1:0] ByteCmdHold = HoldW'(53);
  localparam logic [HoldW-1:0] ClearHold   = HoldW'(3000);

  localparam logic [NibW-1:0] WakeNib  = 4'b0011;
  localparam logic [NibW-1:0] Mode4Nib = 4'b0010;

  typedef enum logic [KindW-1:0] {
    KIND_INIT   = 3'd0,
    KIND_NIB    = 3'd1,
    KIND_BYTE   = 3'd2,
    KIND_CHAR   = 3'd3,
    KIND_CURSOR = 3'd4
  } req_kind_e;

  typedef struct packed {
    logic [NibW-1:0]  nib;
    logic             en;
    logic [HoldW-1:0] hold;
  } phase_t;

  // Init phases from the first nibble strobe on (index 1 to 28)
  function automatic phase_t init_phase(logic [IdxW-1:0] idx);
    phase_t          ph;
    logic [IdxW-1:0] j;
    logic [2:0]      b;
    logic [1:0]      p;
    logic [ByteW-1:0] cmd;
    logic [HoldW-1:0] cmd_hold;
    ph       = '0;
    j        = idx - InitByteIdx;
    b        = j[4:2];
    p        = j[1:0];
    cmd      = 8'b00101000;
    cmd_hold = ByteCmdHold;
    if (idx < InitByteIdx) begin
      // wake-up nibbles 3, 3, 3 then 2
      ph.nib  = (idx >= InitModeIdx) ? Mode4Nib : WakeNib;
      ph.en   = idx[0];
      if (idx[0]) begin
        ph.hold = StrobeHold;
      end else begin
        ph.hold = (idx[IdxW-1:1] == 4'd1) ? WakeHold : NibCmdHold;
      end
    end else begin
      case (b)
        3'd0: cmd = 8'b00101000;
        3'd1: cmd = 8'b00001000;
        3'd2: begin
          cmd      = 8'b00000001;
          cmd_hold = ClearHold;
        end
        3'd3: cmd = 8'b00000110;
        default: cmd = 8'b00001100;
      endcase
      ph.nib = p[1] ? cmd[3:0] : cmd[7:4];
      ph.en  = ~p[0];
      if (!p[0]) begin
        ph.hold = StrobeHold;
      end else if (p[1]) begin
        ph.hold = cmd_hold;
      end else begin
        ph.hold = '0;
      end
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

// File: sv/char_lcd_nibble_interface_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_core: 4-bit character LCD pin phase generator
// Turns each request into enable-strobed pin phases, high nibble first.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// s_axis   in   tvalid/tready        tuser: req_type; tdata: request fields
// m_axis   out  tvalid/tready/tlast  tuser: reg_select; tdata: phase fields
//
// One phase leaves per cycle while m_axis does not stall: a nibble command
// yields 2 phases, a byte, character or cursor move 4, the init sequence 29;
// a request that yields no phase is dropped. The phase counter of the request
// register sets the rate; the next request is taken in the cycle its last phase moves.
// Reset clears pin state and valid flags. A stall on m_axis holds the
// output register and freezes the phase counter.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_interface_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] byte_value, [23:8] hold_delay, [25:24] row, [30:26] column, [31] 0
  input  wire logic [lcd4_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] req_type
  input  wire logic [lcd4_pkg::KindW-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [3:0] data_nibble, [4] enable_level, [20:5] hold_units, [23:21] 0
  output logic [lcd4_pkg::OutDataW-1:0]       m_axis_tdata,
  // [0] reg_select
  output logic                                m_axis_tuser,
  // last_phase
  output logic                                m_axis_tlast
);
  import lcd4_pkg::*;

  // request fields
  logic [ByteW-1:0] in_byte;
  logic [HoldW-1:0] in_hold;
  logic [RowW-1:0]  in_row;
  logic [ColW-1:0]  in_col;

  // current request
  logic             cur_valid_q, cur_valid_d;
  logic             cur_init_q, cur_init_d;
  logic             cur_nib_q, cur_nib_d;
  logic             cur_rs_q, cur_rs_d;
  logic [ByteW-1:0] cur_byte_q, cur_byte_d;
  logic [HoldW-1:0] cur_hold_q, cur_hold_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  // pins left by the last emitted phase
  logic [NibW-1:0]  pin_nib_q;
  logic             pin_rs_q;

  // output register
  logic             out_valid_q;
  logic [NibW-1:0]  out_nib_q;
  logic             out_en_q;
  logic [HoldW-1:0] out_hold_q;
  logic             out_rs_q;
  logic             out_last_q;

  logic    accept;
  logic    advance;
  logic    last;
  logic    produce;
  phase_t  ph;
  phase_t  init_ph;

  assign in_byte = s_axis_tdata[7:0];
  assign in_hold = s_axis_tdata[23:8];
  assign in_row  = s_axis_tdata[25:24];
  assign in_col  = s_axis_tdata[30:26];

  assign init_ph = init_phase(idx_q);

  always_comb begin
    if (cur_init_q) begin
      last = (idx_q == InitLastIdx);
    end else if (cur_nib_q) begin
      last = (idx_q == NibLastIdx);
    end else begin
      last = (idx_q == ByteLastIdx);
    end
  end

  // phase for the current index
  always_comb begin
    ph = '0;
    if (cur_init_q) begin
      if (idx_q == '0) begin
        ph.nib  = pin_nib_q;
        ph.en   = 1'b0;
        ph.hold = WaitHold;
      end else begin
        ph = init_ph;
      end
    end else if (cur_nib_q) begin
      ph.nib  = cur_byte_q[3:0];
      ph.en   = ~idx_q[0];
      ph.hold = idx_q[0] ? cur_hold_q : StrobeHold;
    end else begin
      ph.nib = idx_q[1] ? cur_byte_q[3:0] : cur_byte_q[7:4];
      ph.en  = ~idx_q[0];
      if (!idx_q[0]) begin
        ph.hold = StrobeHold;
      end else if (idx_q[1]) begin
        ph.hold = cur_hold_q;
      end else begin
        ph.hold = '0;
      end
    end
  end

  assign advance       = cur_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !cur_valid_q || (advance && last);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // decode an incoming request
  always_comb begin
    produce    = 1'b0;
    cur_init_d = 1'b0;
    cur_nib_d  = 1'b0;
    cur_rs_d   = 1'b0;
    cur_byte_d = in_byte;
    cur_hold_d = in_hold;
    case (s_axis_tuser)
      KIND_INIT: begin
        produce    = 1'b1;
        cur_init_d = 1'b1;
      end
      KIND_NIB: begin
        produce   = 1'b1;
        cur_nib_d = 1'b1;
      end
      KIND_BYTE: begin
        produce = 1'b1;
      end
      KIND_CHAR: begin
        produce    = 1'b1;
        cur_rs_d   = 1'b1;
        cur_hold_d = CharHold;
      end
      KIND_CURSOR: begin
        // drop rows above 1 and columns above 15
        produce    = !in_row[1] && !in_col[4];
        cur_byte_d = {1'b1, in_row[0], 2'b00, in_col[3:0]};
        cur_hold_d = CharHold;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (accept) begin
      cur_valid_d = produce;
      idx_d       = '0;
    end else if (advance) begin
      // retire the request once its last phase moves
      if (last) begin
        cur_valid_d = 1'b0;
      end
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      pin_nib_q   <= '0;
      pin_rs_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      if (advance) begin
        pin_nib_q   <= ph.nib;
        pin_rs_q    <= cur_init_q ? (idx_q == '0 ? pin_rs_q : 1'b0) : cur_rs_q;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_init_q <= cur_init_d;
      cur_nib_q  <= cur_nib_d;
      cur_rs_q   <= cur_rs_d;
      cur_byte_q <= cur_byte_d;
      cur_hold_q <= cur_hold_d;
    end
    if (advance) begin
      out_nib_q  <= ph.nib;
      out_en_q   <= ph.en;
      out_hold_q <= ph.hold;
      out_last_q <= last;
      if (cur_init_q) begin
        out_rs_q <= (idx_q == '0) ? pin_rs_q : 1'b0;
      end else begin
        out_rs_q <= cur_rs_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_hold_q, out_en_q, out_nib_q};
  assign m_axis_tuser  = out_rs_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for char_lcd_nibble_interface_core
// Sends LCD requests on s_axis and checks every pin phase on m_axis against a
// behavioral model of the phase lists. A directed table comes first, then a
// random request mix, under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lcd4_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandReqs    = 176;
  localparam int unsigned LcdCols     = 16;

  // reserved request kinds, dropped by the block
  localparam logic [KindW-1:0] KindRsvFirst = 3'd5;
  localparam logic [KindW-1:0] KindRsvMid   = 3'd6;
  localparam logic [KindW-1:0] KindRsvLast  = 3'd7;

  // power-up command bytes and cursor address bases
  localparam logic [ByteW-1:0] CmdFuncSet = 8'b00101000;
  localparam logic [ByteW-1:0] CmdDispOff = 8'b00001000;
  localparam logic [ByteW-1:0] CmdClear   = 8'b00000001;
  localparam logic [ByteW-1:0] CmdEntry   = 8'b00000110;
  localparam logic [ByteW-1:0] CmdDispOn  = 8'b00001100;
  localparam logic [ByteW-1:0] CursorRow0 = 8'h80;
  localparam logic [ByteW-1:0] CursorRow1 = 8'hC0;

  typedef struct packed {
    logic [NibW-1:0]  nib;
    logic             rs;
    logic             en;
    logic [HoldW-1:0] hold;
    logic             last;
  } lcd_phase_t;

  // typed rows list the byte on the wire, its register select and final hold
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] val;
    logic [HoldW-1:0] dly;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             typed;
    logic [2:0]       t_cnt;
    logic [ByteW-1:0] t_byte;
    logic             t_rs;
    logic [HoldW-1:0] t_hold;
  } lcd_req_row_t;

  localparam int unsigned NumRows = 24;

  lcd_req_row_t req_tab [NumRows] = '{
    '{KIND_INIT,   8'h00, 16'h0000, 2'd0, 5'd0,  1'b0, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_NIB,    8'h00, 16'h0000, 2'd0, 5'd0,  1'b1, 3'd2, 8'h00, 1'b0, 16'h0000},
    '{KIND_NIB,    8'hFF, 16'hFFFF, 2'd3, 5'd31, 1'b1, 3'd2, 8'h0F, 1'b0, 16'hFFFF},
    '{KIND_NIB,    8'hA5, 16'h1234, 2'd1, 5'd10, 1'b0, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_BYTE,   8'h00, 16'h0000, 2'd0, 5'd0,  1'b1, 3'd4, 8'h00, 1'b0, 16'h0000},
    '{KIND_BYTE,   8'hFF, 16'hFFFF, 2'd3, 5'd31, 1'b1, 3'd4, 8'hFF, 1'b0, 16'hFFFF},
    '{KIND_BYTE,   8'h5A, 16'hA5A5, 2'd2, 5'd21, 1'b0, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_CHAR,   8'h00, 16'hFFFF, 2'd0, 5'd0,  1'b1, 3'd4, 8'h00, 1'b1, CharHold},
    '{KIND_CHAR,   8'hFF, 16'h0000, 2'd3, 5'd31, 1'b1, 3'd4, 8'hFF, 1'b1, CharHold},
    '{KIND_CHAR,   8'hA5, 16'h1234, 2'd0, 5'd0,  1'b1, 3'd4, 8'hA5, 1'b1, CharHold},
    '{KIND_CURSOR, 8'hFF, 16'hFFFF, 2'd0, 5'd0,  1'b1, 3'd4, 8'h80, 1'b0, CharHold},
    '{KIND_CURSOR, 8'h00, 16'h0000, 2'd0, 5'd15, 1'b1, 3'd4, 8'h8F, 1'b0, CharHold},
    '{KIND_CURSOR, 8'h00, 16'h0000, 2'd1, 5'd0,  1'b1, 3'd4, 8'hC0, 1'b0, CharHold},
    '{KIND_CURSOR, 8'hFF, 16'hFFFF, 2'd1, 5'd15, 1'b1, 3'd4, 8'hCF, 1'b0, CharHold},
    '{KIND_CURSOR, 8'h00, 16'h0000, 2'd2, 5'd0,  1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_CURSOR, 8'hFF, 16'hFFFF, 2'd3, 5'd31, 1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_CURSOR, 8'h00, 16'h0000, 2'd0, 5'd16, 1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_CURSOR, 8'h00, 16'h0000, 2'd1, 5'd31, 1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KindRsvFirst, 8'hFF, 16'hFFFF, 2'd3, 5'd31, 1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KindRsvMid,  8'h00, 16'h0000, 2'd0, 5'd0,  1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KindRsvLast, 8'hFF, 16'hFFFF, 2'd1, 5'd5,  1'b1, 3'd0, 8'h00, 1'b0, 16'h0000},
    // init now holds the pins left by the last cursor move
    '{KIND_INIT,   8'h00, 16'h0000, 2'd0, 5'd0,  1'b0, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_CHAR,   8'h3C, 16'h0000, 2'd0, 5'd0,  1'b0, 3'd0, 8'h00, 1'b0, 16'h0000},
    '{KIND_INIT,   8'hFF, 16'hFFFF, 2'd3, 5'd31, 1'b0, 3'd0, 8'h00, 1'b0, 16'h0000}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles  = 0;
  int unsigned mismatch_cnt  = 0;

  // pin levels left by the last predicted phase
  logic [NibW-1:0] lcd_nib = '0;
  logic            lcd_rs  = 1'b0;

  lcd_phase_t built_q [$];
  lcd_phase_t listed_q [$];
  lcd_phase_t due_phases_q [$];

  char_lcd_nibble_interface_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic void push_phase(logic [NibW-1:0] nib, logic rs, logic en,
                                     logic [HoldW-1:0] hold);
    lcd_nib = nib;
    lcd_rs  = rs;
    built_q.push_back('{nib, rs, en, hold, 1'b0});
  endfunction

  function automatic void push_nibble(logic [NibW-1:0] nib, logic [HoldW-1:0] hold);
    push_phase(nib, 1'b0, 1'b1, StrobeHold);
    push_phase(nib, 1'b0, 1'b0, hold);
  endfunction

  // high nibble first, each nibble strobed high then low
  function automatic void push_byte(logic [ByteW-1:0] b, logic rs, logic [HoldW-1:0] hold);
    push_phase(b[7:4], rs, 1'b1, StrobeHold);
    push_phase(b[7:4], rs, 1'b0, '0);
    push_phase(b[3:0], rs, 1'b1, StrobeHold);
    push_phase(b[3:0], rs, 1'b0, hold);
  endfunction

  function automatic void build_phases(logic [KindW-1:0] kind, logic [ByteW-1:0] val,
                                       logic [HoldW-1:0] dly, logic [RowW-1:0] row,
                                       logic [ColW-1:0] col);
    lcd_phase_t tail;
    built_q.delete();
    case (kind)
      KIND_INIT: begin
        push_phase(lcd_nib, lcd_rs, 1'b0, WaitHold);
        push_nibble(WakeNib, WakeHold);
        push_nibble(WakeNib, NibCmdHold);
        push_nibble(WakeNib, NibCmdHold);
        push_nibble(Mode4Nib, NibCmdHold);
        push_byte(CmdFuncSet, 1'b0, ByteCmdHold);
        push_byte(CmdDispOff, 1'b0, ByteCmdHold);
        push_byte(CmdClear, 1'b0, ClearHold);
        push_byte(CmdEntry, 1'b0, ByteCmdHold);
        push_byte(CmdDispOn, 1'b0, ByteCmdHold);
      end
      KIND_NIB:  push_nibble(val[3:0], dly);
      KIND_BYTE: push_byte(val, 1'b0, dly);
      KIND_CHAR: push_byte(val, 1'b1, CharHold);
      KIND_CURSOR: begin
        // off-screen positions are dropped
        if (col < LcdCols && row == 2'd0) begin
          push_byte(CursorRow0 | {4'h0, col[3:0]}, 1'b0, CharHold);
        end else if (col < LcdCols && row == 2'd1) begin
          push_byte(CursorRow1 | {4'h0, col[3:0]}, 1'b0, CharHold);
        end
      end
      default: ;
    endcase
    if (built_q.size() > 0) begin
      tail      = built_q.pop_back();
      tail.last = 1'b1;
      built_q.push_back(tail);
    end
  endfunction

  task automatic send_request(input logic [KindW-1:0] kind, input logic [ByteW-1:0] val,
                              input logic [HoldW-1:0] dly, input logic [RowW-1:0] row,
                              input logic [ColW-1:0] col, input logic typed,
                              output int n_phases);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, col, row, dly, val};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    build_phases(kind, val, dly, row, col);
    n_phases = built_q.size();
    if (typed) begin
      foreach (listed_q[i]) due_phases_q.push_back(listed_q[i]);
    end else begin
      foreach (built_q[i]) due_phases_q.push_back(built_q[i]);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    lcd_phase_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_phases_q.size() == 0) begin
        $error("unexpected phase beat: tdata %0h tuser %0b tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = due_phases_q.pop_front();
        if (m_axis_tdata[3:0] !== want.nib) begin
          $error("data_nibble: expected %0h, got %0h", want.nib, m_axis_tdata[3:0]);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.rs) begin
          $error("reg_select: expected %0b, got %0b", want.rs, m_axis_tuser);
          mismatch_cnt++;
        end
        if (m_axis_tdata[4] !== want.en) begin
          $error("enable_level: expected %0b, got %0b", want.en, m_axis_tdata[4]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[20:5] !== want.hold) begin
          $error("hold_units: expected %0d, got %0d", want.hold, m_axis_tdata[20:5]);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_phase: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // count cycles in which no beat moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    lcd_phase_t       ph;
    int               n_ph;
    int unsigned      n_useful;
    int unsigned      pick;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] val;
    logic [HoldW-1:0] dly;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;

    send_idle_pct = 38;
    recv_idle_pct = 87;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (req_tab[r]) begin
      listed_q.delete();
      for (int i = 0; i < int'(req_tab[r].t_cnt); i++) begin
        ph.nib  = (req_tab[r].t_cnt == 3'd4 && i < 2) ? req_tab[r].t_byte[7:4]
                                                       : req_tab[r].t_byte[3:0];
        ph.rs   = req_tab[r].t_rs;
        ph.en   = (i % 2 == 0);
        ph.last = (i == int'(req_tab[r].t_cnt) - 1);
        if (i % 2 == 0) begin
          ph.hold = StrobeHold;
        end else begin
          ph.hold = ph.last ? req_tab[r].t_hold : '0;
        end
        listed_q.push_back(ph);
      end
      send_request(req_tab[r].kind, req_tab[r].val, req_tab[r].dly, req_tab[r].row,
                   req_tab[r].col, req_tab[r].typed, n_ph);
    end

    n_useful = 0;
    while (n_useful < RandReqs) begin
      // swap the stall profile a third of the way in, then run without stalls
      if (n_useful >= 2 * RandReqs / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_useful >= RandReqs / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 38;
      end
      pick = $urandom_range(99);
      val  = ByteW'($urandom);
      dly  = HoldW'($urandom);
      row  = RowW'($urandom);
      col  = ColW'($urandom);
      if (pick < 5) begin
        kind = KIND_INIT;
      end else if (pick < 20) begin
        kind = KIND_NIB;
      end else if (pick < 45) begin
        kind = KIND_BYTE;
      end else if (pick < 70) begin
        kind = KIND_CHAR;
      end else if (pick < 95) begin
        kind = KIND_CURSOR;
        // mostly on-screen positions
        if ($urandom_range(9) < 8) begin
          row = RowW'($urandom_range(1));
          col = ColW'($urandom_range(LcdCols - 1));
        end
      end else begin
        kind = KindW'($urandom_range(KindRsvLast, KindRsvFirst));
      end
      send_request(kind, val, dly, row, col, 1'b0, n_ph);
      if (n_ph > 0) n_useful++;
    end

    s_axis_tvalid <= 1'b0;
    while (due_phases_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
